>>> design/signed_integer_divider_core_defines.svh
// ----------------------------------------------------------------------------
// signed integer divider assertion macros
// shared property forms for the divider's concurrent checks
// ----------------------------------------------------------------------------
`ifndef SIGNED_INTEGER_DIVIDER_CORE_DEFINES_SVH
`define SIGNED_INTEGER_DIVIDER_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define SIDIV_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define SIDIV_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/sidiv_pkg.sv
// ----------------------------------------------------------------------------
// sidiv_pkg
// shared types and constants of the signed integer divider
// ----------------------------------------------------------------------------
package sidiv_pkg;

    // default operand width
    localparam int DATA_WIDTH_DEF = 32;

    // width of the status field
    localparam int STATUS_W = 2;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK   = 2'd0,
        ST_SAT  = 2'd1,
        ST_DIV0 = 2'd2
    } sidiv_status_t;

    // control group that travels with each item through the pipeline
    typedef struct packed {
        logic          valid;
        logic          neg;
        sidiv_status_t status;
    } sidiv_ctl_t;

endpackage

>>> design/sidiv_step.sv
// ----------------------------------------------------------------------------
// sidiv_step
// one registered restoring shift-subtract step of the divider pipeline
// ----------------------------------------------------------------------------
module sidiv_step
    import sidiv_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  sidiv_ctl_t            ctl_in,
    input  logic [DATA_WIDTH-1:0] rem_in,
    input  logic [DATA_WIDTH-1:0] aq_in,
    input  logic [DATA_WIDTH-1:0] ud_in,
    output sidiv_ctl_t            ctl_out,
    output logic [DATA_WIDTH-1:0] rem_out,
    output logic [DATA_WIDTH-1:0] aq_out,
    output logic [DATA_WIDTH-1:0] ud_out
);

    sidiv_ctl_t            ctl_reg;
    logic [DATA_WIDTH-1:0] rem_reg;
    logic [DATA_WIDTH-1:0] rem_next;
    logic [DATA_WIDTH-1:0] aq_reg;
    logic [DATA_WIDTH-1:0] aq_next;
    logic [DATA_WIDTH-1:0] ud_reg;
    logic [DATA_WIDTH:0]   trial;
    logic                  qbit;

    // shift in the next dividend bit and try the subtract
    always_comb
    begin
        trial = {rem_in, aq_in[DATA_WIDTH-1]} - {1'b0, ud_in};
        qbit  = ~trial[DATA_WIDTH];
        if (qbit)
        begin
            rem_next = trial[DATA_WIDTH-1:0];
        end
        else
        begin
            rem_next = {rem_in[DATA_WIDTH-2:0], aq_in[DATA_WIDTH-1]};
        end
        aq_next = {aq_in[DATA_WIDTH-2:0], qbit};
    end

    // control register, cleared on reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (en)
        begin
            ctl_reg <= ctl_in;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg <= rem_next;
            aq_reg  <= aq_next;
            ud_reg  <= ud_in;
        end
    end

    assign ctl_out = ctl_reg;
    assign rem_out = rem_reg;
    assign aq_out  = aq_reg;
    assign ud_out  = ud_reg;

endmodule

>>> design/signed_integer_divider_core.sv
// ----------------------------------------------------------------------------
// signed_integer_divider_core
// pipelined signed divider, quotient truncated toward zero
// ----------------------------------------------------------------------------
// channel   valid      stall      payload
// request   req_valid  req_stall  dividend, divisor
// response  rsp_valid  rsp_stall  quotient, status
//
// the pipeline has one entry stage for magnitudes and special cases, one stage
// per quotient bit and one stage for sign and status.
// one transfer per cycle is taken in steady state while no response is stalled.
// a stalled response freezes the whole pipeline; req_stall follows it.
// reset clears only the control registers: valid, sign and status.
// ----------------------------------------------------------------------------
`include "signed_integer_divider_core_defines.svh"

module signed_integer_divider_core
    import sidiv_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         req_valid,
    output logic                         req_stall,
    input  logic signed [DATA_WIDTH-1:0] dividend,
    input  logic signed [DATA_WIDTH-1:0] divisor,
    output logic                         rsp_valid,
    input  logic                         rsp_stall,
    output logic signed [DATA_WIDTH-1:0] quotient,
    output logic [STATUS_W-1:0]          status
);

    logic                  en;
    sidiv_ctl_t            entry_ctl_next;
    sidiv_ctl_t            entry_ctl_reg;
    logic [DATA_WIDTH-1:0] ua_next;
    logic [DATA_WIDTH-1:0] ud_next;
    logic [DATA_WIDTH-1:0] ua_reg;
    logic [DATA_WIDTH-1:0] ud_reg;

    sidiv_ctl_t            ctl_pipe [0:DATA_WIDTH];
    logic [DATA_WIDTH-1:0] rem_pipe [0:DATA_WIDTH];
    logic [DATA_WIDTH-1:0] aq_pipe  [0:DATA_WIDTH];
    logic [DATA_WIDTH-1:0] ud_pipe  [0:DATA_WIDTH];

    logic                  out_valid_reg;
    logic [DATA_WIDTH-1:0] quotient_reg;
    logic [DATA_WIDTH-1:0] quotient_next;
    sidiv_status_t         status_reg;
    logic [DATA_WIDTH-1:0] q_final;

    // pipeline advances unless a finished result is held
    assign en        = ~(out_valid_reg & rsp_stall);
    assign req_stall = ~en;

    // magnitudes, sign and special cases of the incoming transfer
    always_comb
    begin
        ua_next = dividend[DATA_WIDTH-1] ? (~dividend + 1'b1) : dividend;
        ud_next = divisor[DATA_WIDTH-1] ? (~divisor + 1'b1) : divisor;
        entry_ctl_next.valid  = req_valid;
        entry_ctl_next.neg    = dividend[DATA_WIDTH-1] ^ divisor[DATA_WIDTH-1];
        entry_ctl_next.status = ST_OK;
        if (divisor == '0)
        begin
            entry_ctl_next.status = ST_DIV0;
        end
        else if ((dividend == {1'b1, {(DATA_WIDTH-1){1'b0}}}) && (divisor == '1))
        begin
            entry_ctl_next.status = ST_SAT;
        end
    end

    // entry stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_ctl_reg <= '0;
        end
        else if (en)
        begin
            entry_ctl_reg <= entry_ctl_next;
        end
    end

    // entry stage payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ua_reg <= ua_next;
            ud_reg <= ud_next;
        end
    end

    assign ctl_pipe[0] = entry_ctl_reg;
    assign rem_pipe[0] = '0;
    assign aq_pipe[0]  = ua_reg;
    assign ud_pipe[0]  = ud_reg;

    // one quotient bit per stage, most significant first
    for (genvar i = 0; i < DATA_WIDTH; i++)
    begin : g_step
        sidiv_step #(
            .DATA_WIDTH (DATA_WIDTH)
        ) u_step (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (en),
            .ctl_in  (ctl_pipe[i]),
            .rem_in  (rem_pipe[i]),
            .aq_in   (aq_pipe[i]),
            .ud_in   (ud_pipe[i]),
            .ctl_out (ctl_pipe[i+1]),
            .rem_out (rem_pipe[i+1]),
            .aq_out  (aq_pipe[i+1]),
            .ud_out  (ud_pipe[i+1])
        );
    end

    // apply sign and special-case results
    always_comb
    begin
        q_final = ctl_pipe[DATA_WIDTH].neg ? (~aq_pipe[DATA_WIDTH] + 1'b1)
                                           : aq_pipe[DATA_WIDTH];
        case (ctl_pipe[DATA_WIDTH].status)
            ST_OK:   quotient_next = q_final;
            ST_SAT:  quotient_next = {1'b0, {(DATA_WIDTH-1){1'b1}}};
            ST_DIV0: quotient_next = '0;
            default: quotient_next = '0;
        endcase
    end

    // output register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= ctl_pipe[DATA_WIDTH].valid;
        end
    end

    // output register payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            quotient_reg <= quotient_next;
            status_reg   <= ctl_pipe[DATA_WIDTH].status;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign quotient  = quotient_reg;
    assign status    = status_reg;

    // checks
    `SIDIV_ASSERT_NXT(a_accept_enters, req_valid && !req_stall, entry_ctl_reg.valid, "accepted transfer did not enter the pipeline")
    `SIDIV_ASSERT_IMP(a_rem_bound, ctl_pipe[DATA_WIDTH].valid && (ctl_pipe[DATA_WIDTH].status == ST_OK), rem_pipe[DATA_WIDTH] < ud_pipe[DATA_WIDTH], "final remainder not below divisor magnitude")
    `SIDIV_ASSERT_IMP(a_div0_zero, rsp_valid && (status_reg == ST_DIV0), quotient_reg == '0, "divide by zero gave a nonzero quotient")

endmodule

>>> tb/signed_integer_divider_core_test.sv
// ----------------------------------------------------------------------------
// signed_integer_divider_core_test
// checks each quotient and status of the pipelined signed divider against a
// bit-exact restoring-division predictor, with corner operands, random
// operands, back-to-back traffic and a long response hold-off
// ----------------------------------------------------------------------------
module signed_integer_divider_core_test;
    import sidiv_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DW          = DATA_WIDTH_DEF;
    localparam int HOLD_CYCLES = 150;
    localparam int STUCK_LIMIT = 1000;

    localparam logic [DW-1:0] MOST_NEG = {1'b1, {(DW-1){1'b0}}};
    localparam logic [DW-1:0] MOST_POS = {1'b0, {(DW-1){1'b1}}};
    localparam logic [DW-1:0] MINUS_ONE = {DW{1'b1}};

    // one predicted division, operands kept for reporting
    typedef struct {
        logic [DW-1:0] num;
        logic [DW-1:0] den;
        logic [DW-1:0] quotient;
        sidiv_status_t status;
    } division_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 req_valid = 1'b0;
    logic                 req_stall;
    logic signed [DW-1:0] dividend = '0;
    logic signed [DW-1:0] divisor = '0;
    logic                 rsp_valid;
    logic                 rsp_stall = 1'b0;
    logic signed [DW-1:0] quotient;
    logic [STATUS_W-1:0]  status;

    division_t pending_quotients[$];
    int        mismatch_count = 0;
    int        stuck_cycles = 0;
    bit        send_idle_on = 1'b0;
    bit        rsp_idle_on = 1'b0;
    logic      hold_req = 1'b0;
    int        hold_left = 0;

    signed_integer_divider_core #(
        .DATA_WIDTH (DW)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .dividend  (dividend),
        .divisor   (divisor),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .quotient  (quotient),
        .status    (status)
    );

    // 2 ns clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // quotient truncated toward zero via restoring division on magnitudes
    function automatic division_t predict_quotient(input logic [DW-1:0] num,
                                                   input logic [DW-1:0] den);
        division_t     d;
        logic [DW-1:0] mag_num;
        logic [DW-1:0] mag_den;
        logic [DW-1:0] acc;
        logic [DW:0]   rem;
        logic          negative;
        d.num = num;
        d.den = den;
        d.quotient = '0;
        d.status = ST_OK;
        if (den == '0)
        begin
            d.status = ST_DIV0;
        end
        else if (num == MOST_NEG && den == MINUS_ONE)
        begin
            d.quotient = MOST_POS;
            d.status = ST_SAT;
        end
        else
        begin
            mag_num = num[DW-1] ? -num : num;
            mag_den = den[DW-1] ? -den : den;
            negative = num[DW-1] ^ den[DW-1];
            rem = '0;
            acc = '0;
            for (int i = DW - 1; i >= 0; i--)
            begin
                rem = {rem[DW-1:0], mag_num[i]};
                if (rem >= {1'b0, mag_den})
                begin
                    rem = rem - {1'b0, mag_den};
                    acc[i] = 1'b1;
                end
            end
            d.quotient = negative ? -acc : acc;
        end
        return d;
    endfunction

    // transfers are sampled mid-cycle, settled before the edge that takes them
    always @(negedge clk)
    begin
        division_t want;
        bit        moved;
        moved = 1'b0;
        if (rst_n)
        begin
            if (rsp_valid && !rsp_stall)
            begin
                moved = 1'b1;
                if (pending_quotients.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t: response with nothing pending, quotient %0d status %0d",
                             $time, quotient, status);
                end
                else
                begin
                    want = pending_quotients.pop_front();
                    if (quotient !== want.quotient)
                    begin
                        mismatch_count++;
                        $display("%0t: quotient of %0d / %0d expected %0d actual %0d",
                                 $time, $signed(want.num), $signed(want.den),
                                 $signed(want.quotient), quotient);
                    end
                    if (status !== want.status)
                    begin
                        mismatch_count++;
                        $display("%0t: status of %0d / %0d expected %0d actual %0d",
                                 $time, $signed(want.num), $signed(want.den),
                                 want.status, status);
                    end
                end
            end
            if (req_valid && !req_stall)
            begin
                moved = 1'b1;
                pending_quotients.insert(pending_quotients.size(),
                                         predict_quotient(dividend, divisor));
            end
            stuck_cycles = moved ? 0 : stuck_cycles + 1;
        end
    end

    // response side: long hold-off on request, else random or no stalls
    always @(posedge clk)
    begin
        if (hold_req)
        begin
            hold_req <= 1'b0;
            hold_left <= HOLD_CYCLES;
            rsp_stall <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            rsp_stall <= 1'b1;
        end
        else if (rsp_idle_on)
        begin
            rsp_stall <= ($urandom_range(0, 99) < 31);
        end
        else
        begin
            rsp_stall <= 1'b0;
        end
    end

    // watchdog on cycles without any transfer
    initial
    begin
        while (stuck_cycles < STUCK_LIMIT)
            @(posedge clk);
        $display("tb: failure");
        $finish;
    end

    // offer one division and hold it until the transfer
    task automatic send_division(input logic [DW-1:0] num, input logic [DW-1:0] den);
        bit stalled;
        while (send_idle_on && $urandom_range(0, 99) < 31)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        dividend <= num;
        divisor <= den;
        do
        begin
            @(negedge clk);
            stalled = req_stall;
            @(posedge clk);
        end
        while (stalled);
    endtask

    // operand drawn from a spread of magnitudes and special values
    function automatic logic [DW-1:0] pick_operand();
        logic [DW-1:0] v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: v = $urandom;
            4, 5:       v = $urandom_range(0, 200);
            6:          v = -$urandom_range(0, 200);
            7:          v = $signed($urandom) >>> $urandom_range(0, DW - 1);
            default:
            begin
                case ($urandom_range(0, 4))
                    0:       v = '0;
                    1:       v = 1;
                    2:       v = MINUS_ONE;
                    3:       v = MOST_NEG;
                    default: v = MOST_POS;
                endcase
            end
        endcase
        return v;
    endfunction

    task automatic send_random_divisions(input int count);
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(0, 39) == 0)
                send_division(MOST_NEG, MINUS_ONE);
            else
                send_division(pick_operand(), pick_operand());
        end
    endtask

    // extremes, sign combinations, overflow and divide by zero
    task automatic test_corner_divisions();
        send_idle_on = 1'b0;
        rsp_idle_on = 1'b0;
        send_division(0, 1);
        send_division(1, 1);
        send_division(MINUS_ONE, 1);
        send_division(MOST_NEG, 1);
        send_division(MOST_POS, 1);
        send_division(MOST_NEG, MINUS_ONE);
        send_division(MOST_POS, MINUS_ONE);
        send_division(MOST_NEG, 0);
        send_division(0, 0);
        send_division(MOST_POS, 0);
        send_division(MINUS_ONE, 0);
        send_division(7, 2);
        send_division(-7, 2);
        send_division(7, -2);
        send_division(-7, -2);
        send_division(MOST_NEG, MOST_NEG);
        send_division(MOST_POS, MOST_NEG);
        send_division(MOST_NEG, MOST_POS);
        send_division(1, MOST_NEG);
        send_division(MINUS_ONE, MINUS_ONE);
        send_division(5, 7);
        send_division(MOST_NEG, 2);
        send_division(MOST_NEG, -2);
        send_division(123456789, -1000);
    endtask

    // random operands with random gaps on both sides
    task automatic test_random_divisions(input int count);
        send_idle_on = 1'b1;
        rsp_idle_on = 1'b1;
        send_random_divisions(count);
    endtask

    // one transfer per cycle, no gaps and no stalls
    task automatic test_back_to_back_divisions(input int count);
        send_idle_on = 1'b0;
        rsp_idle_on = 1'b0;
        send_random_divisions(count);
    endtask

    // receiver holds off while requests keep coming, so the pipeline fills
    task automatic test_full_pipeline_stall(input int count);
        send_idle_on = 1'b0;
        rsp_idle_on = 1'b0;
        hold_req <= 1'b1;
        send_random_divisions(count);
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_corner_divisions();
        test_random_divisions(650);
        test_back_to_back_divisions(500);
        test_full_pipeline_stall(120);
        test_random_divisions(380);

        // drain the pipeline, then let the latency pass
        req_valid <= 1'b0;
        while (pending_quotients.size() > 0)
            @(posedge clk);
        repeat (DW + 8) @(posedge clk);

        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
